### rtl/bitmap_block_allocator_defines.svh
// Assertion macros shared by the bitmap allocator RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bba_pkg.sv
// Shared types and constants of the bitmap allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package bba_pkg;

    localparam logic       CMD_ALLOC   = 1'b0;
    localparam logic       CMD_FREE    = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_OOR  = 2'd2;

    localparam logic [7:0] BYTE_FULL   = 8'hFF;
    localparam int         GRANT_W     = 7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RES_GRANT,
        RES_OK,
        RES_FULL,
        RES_OOR
    } t_res;

    typedef struct packed {
        logic load_item;
        logic ptr_clear;
        logic ptr_inc;
        logic rd_en;
        logic rd_free;
        logic wr_clear;
        logic wr_alloc;
        logic wr_free;
        logic res_load;
        t_res res;
    } t_dp_cmd;

    typedef struct packed {
        logic last_ptr;
        logic data_last;
        logic found;
        logic oor;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/bba_ctrl.sv
// Sequencer of the bitmap allocator: clearing pass, scan, read-modify-write.
// Depends on bba_pkg and the assertion macros in bitmap_block_allocator_defines.svh.
`default_nettype none
`include "bitmap_block_allocator_defines.svh"

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire logic    i_command,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.last_ptr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_command == CMD_FREE) ? S_FREE_RD : S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC_SCAN;
            end
            S_ALLOC_SCAN: begin
                priority if (i_sts.found) begin
                    n_res   = RES_GRANT;
                    n_state = S_RESULT;
                end else if (i_sts.data_last) begin
                    n_res   = RES_FULL;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_ALLOC_SCAN;
                end
            end
            S_FREE_RD: begin
                if (i_sts.oor) begin
                    n_res   = RES_OOR;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                n_res   = RES_OK;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd     = '0;
        o_cmd.res = r_res;
        o_stall   = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_clear = 1'b1;
                if (i_sts.last_ptr) begin
                    o_cmd.ptr_clear = 1'b1;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.ptr_clear = 1'b1;
                end
            end
            S_ALLOC_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            S_ALLOC_SCAN: begin
                priority if (i_sts.found) begin
                    o_cmd.wr_alloc = 1'b1;
                end else begin
                    // advance to the next byte unless the last one is exhausted
                    o_cmd.rd_en   = ~i_sts.data_last;
                    o_cmd.ptr_inc = ~i_sts.data_last;
                end
            end
            S_FREE_RD: begin
                if (!i_sts.oor) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_free = 1'b1;
                end
            end
            S_FREE_WR: begin
                o_cmd.wr_free = 1'b1;
            end
            S_RESULT: begin
                o_cmd.res_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `BBA_ASSERT_SAME(a_res_into_free_slot, o_cmd.res_load, i_sts.out_free,
        "result loaded while output register still held")
    `BBA_ASSERT_SAME(a_one_writer, 1'b1,
        $onehot0({o_cmd.wr_clear, o_cmd.wr_alloc, o_cmd.wr_free}),
        "more than one bitmap write in a cycle")
    `BBA_ASSERT_NEXT(a_alloc_then_result, o_cmd.wr_alloc,
        (r_state == S_RESULT) && (r_res == RES_GRANT),
        "grant write not followed by a grant result")

endmodule

`default_nettype wire

### rtl/bba_dpath.sv
// Datapath of the bitmap allocator: byte-wide bitmap memory, scan pointer,
// first-zero search, item capture and result register. Depends on bba_pkg and the macros.
`default_nettype none
`include "bitmap_block_allocator_defines.svh"

module bba_dpath
    import bba_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_command,
    input  wire logic [7:0]   i_entry_index,
    input  wire logic         i_stall,
    output logic              o_valid,
    output logic [GRANT_W-1:0] o_granted_index,
    output logic [1:0]        o_status,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_sts           o_sts
);

    localparam int MAP_BYTES = (ENTRIES + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int IDX_W     = ADDR_W + 3;
    localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(MAP_BYTES - 1);
    // Bits past the last entry in a partial last byte count as taken.
    localparam logic [7:0] PAD_MASK =
        ((ENTRIES % 8) == 0) ? 8'h00 : 8'(8'hFF << (ENTRIES % 8));

    logic [7:0]         r_mem [MAP_BYTES];
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [7:0]         r_rd_data;
    logic [ADDR_W-1:0]  r_data_addr;
    logic               r_cmd;
    logic [7:0]         r_idx;
    logic [GRANT_W-1:0] r_grant;
    logic               r_out_valid, n_out_valid;
    logic [GRANT_W-1:0] r_out_granted;
    logic [1:0]         r_out_status;

    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  free_byte;
    logic [7:0]         masked;
    logic [2:0]         bit_sel;
    logic               found;
    logic [IDX_W-1:0]   full_idx;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               oor;

    // Scan / clear pointer
    always_comb begin
        priority if (i_cmd.ptr_clear) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + 1'b1;
        end else begin
            n_ptr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd <= i_command;
            r_idx <= i_entry_index;
        end
    end

    assign free_byte = ADDR_W'(r_idx[7:3]);
    assign oor       = (32'(r_idx) >= 32'(ENTRIES));
    assign rd_addr   = i_cmd.rd_free ? free_byte : r_ptr;

    // Memory read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data   <= r_mem[rd_addr];
            r_data_addr <= rd_addr;
        end
    end

    // Lowest clear bit of the byte just read
    assign masked = r_rd_data | ((r_data_addr == LAST_BYTE) ? PAD_MASK : 8'h00);
    assign found  = (masked != BYTE_FULL);

    always_comb begin
        bit_sel = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (!masked[b]) begin
                bit_sel = 3'(b);
            end
        end
    end

    assign full_idx = {r_data_addr, bit_sel};

    // Memory write port
    always_comb begin
        wr_en   = i_cmd.wr_clear | i_cmd.wr_alloc | i_cmd.wr_free;
        wr_addr = r_data_addr;
        priority if (i_cmd.wr_clear) begin
            wr_addr = r_ptr;
            wr_data = 8'h00;
        end else if (i_cmd.wr_alloc) begin
            wr_data = r_rd_data | (8'h01 << bit_sel);
        end else begin
            wr_data = r_rd_data & ~(8'h01 << r_idx[2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_alloc) begin
            r_grant <= GRANT_W'(full_idx);
        end
    end

    // Result register
    assign n_out_valid = i_cmd.res_load | (r_out_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res)
                RES_GRANT: begin
                    r_out_granted <= r_grant;
                    r_out_status  <= STATUS_OK;
                end
                RES_OK: begin
                    r_out_granted <= '0;
                    r_out_status  <= STATUS_OK;
                end
                RES_FULL: begin
                    r_out_granted <= '0;
                    r_out_status  <= STATUS_FULL;
                end
                RES_OOR: begin
                    r_out_granted <= '0;
                    r_out_status  <= STATUS_OOR;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_granted_index = r_out_granted;
    assign o_status        = r_out_status;

    assign o_sts.last_ptr  = (r_ptr == LAST_BYTE);
    assign o_sts.data_last = (r_data_addr == LAST_BYTE);
    assign o_sts.found     = found;
    assign o_sts.oor       = oor | (r_cmd != CMD_FREE);
    assign o_sts.out_free  = ~r_out_valid | ~i_stall;

    `BBA_ASSERT_SAME(a_read_in_range, i_cmd.rd_en, rd_addr <= LAST_BYTE,
        "bitmap read beyond last byte")
    `BBA_ASSERT_SAME(a_grant_in_range, i_cmd.wr_alloc, 32'(full_idx) < 32'(ENTRIES),
        "granted entry beyond the bitmap")
    `BBA_ASSERT_SAME(a_grant_only_ok, r_out_valid && (r_out_status != STATUS_OK),
        r_out_granted == '0, "non-zero index on a failed result")

endmodule

`default_nettype wire

### rtl/bitmap_block_allocator.sv
// Top level of the bitmap allocator: ties the sequencer to the datapath.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
//  channel  direction  handshake          payload
//  item     in         i_valid / o_stall  i_command, i_entry_index
//  result   out        o_valid / i_stall  o_granted_index, o_status
//
// After reset a clearing pass zeroes the bitmap, one byte a cycle, all
//   (ENTRIES+7)/8 bytes (16 at 128 entries), with o_stall high.
// One item at a time: o_stall stays high until the item's result is loaded.
// Allocate: reads the bitmap a byte at a time from byte 0 until one has a clear bit
//   (1 .. (ENTRIES+7)/8 bytes read), sets it, then loads the result; full if none is clear.
// Free: read, modify-write, result; out of range: result only, no bitmap access.
// The result stage holds while the result register is full and i_stall is high.
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [7:0]         i_entry_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [GRANT_W-1:0]      o_granted_index,
    output logic [1:0]              o_status
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer: decides on each cycle what the datapath does
    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    // Bitmap store, search and result register
    bba_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_command),
        .i_entry_index   (i_entry_index),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts)
    );

endmodule

`default_nettype wire
